// ===== design/assert_macros.svh =====
// assertion macros shared by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/htpe_pkg.sv =====
// types and constants of the hex tile predictive encoder
`timescale 1ns / 1ps

package htpe_pkg;

   localparam int unsigned RING_CELLS = 6;

   localparam logic [7:0] RESID_OFFSET = 8'd128;
   localparam logic [7:0] EDGE_THRESHOLD_RESET = 8'd32;
   localparam logic [3:0] BYTES_FLAT = 4'd2;
   localparam logic [3:0] BYTES_FULL = 4'd9;

   typedef enum logic [1:0] {
      TILE_FLAT = 2'd0,
      TILE_TRIPLET = 2'd1,
      TILE_GRADIENT = 2'd2,
      TILE_EDGE = 2'd3
   } tile_kind_type;

   typedef struct packed {
      logic [7:0] cell_0;
      logic [7:0] cell_1;
      logic [7:0] cell_2;
      logic [7:0] cell_3;
      logic [7:0] cell_4;
      logic [7:0] cell_5;
      logic [7:0] cell_center;
   } req_payload_type;

   typedef struct packed {
      tile_kind_type tile_type;
      logic [7:0] lead_byte;
      logic [7:0] resid_0;
      logic [7:0] resid_1;
      logic [7:0] resid_2;
      logic [7:0] resid_3;
      logic [7:0] resid_4;
      logic [7:0] resid_5;
      logic [7:0] resid_center;
      logic [3:0] byte_count;
   } rsp_payload_type;

   // what the first stage found about one tile
   typedef struct packed {
      logic flat;
      logic triplet;
      logic [7:0] min_val;
      logic [7:0] max_val;
      logic [7:0] mid_avg;
   } tile_info_type;

endpackage

// ===== design/htpe_triplet_lane.sv =====
// one ring-pair-plus-center uniformity check
`timescale 1ns / 1ps

module htpe_triplet_lane (
   input  logic [7:0] cell_a,
   input  logic [7:0] cell_b,
   input  logic [7:0] cell_center,
   output logic       uniform
);

   assign uniform = (cell_a == cell_b) && (cell_b == cell_center);

endmodule

// ===== design/htpe_resid_lane.sv =====
// offset-128 residual of one cell against the prediction, zero for a flat tile
`timescale 1ns / 1ps

module htpe_resid_lane (
   input  logic [7:0] cell_value,
   input  logic [7:0] pred,
   input  logic       flat,
   output logic [7:0] resid
);

   assign resid = flat ? 8'd0 : (cell_value - pred + htpe_pkg::RESID_OFFSET);

endmodule

// ===== design/htpe_median6.sv =====
// floor average of the two middle values of six ring cells
`timescale 1ns / 1ps

module htpe_median6 (
   input  logic [7:0] ring [6],
   output logic [7:0] mid_avg
);

   logic [7:0] s0 [6];
   logic [7:0] s1 [6];
   logic [7:0] s2 [6];
   logic [7:0] s3 [6];
   logic [7:0] s4 [6];
   logic [7:0] s5 [6];
   logic [8:0] mid_sum;

   // 12-comparator, depth-5 sorting network
   always_comb begin
      s0 = ring;
      s1 = s0;
      if (s0[5] < s0[0]) begin s1[0] = s0[5]; s1[5] = s0[0]; end
      if (s0[3] < s0[1]) begin s1[1] = s0[3]; s1[3] = s0[1]; end
      if (s0[4] < s0[2]) begin s1[2] = s0[4]; s1[4] = s0[2]; end
      s2 = s1;
      if (s1[2] < s1[1]) begin s2[1] = s1[2]; s2[2] = s1[1]; end
      if (s1[4] < s1[3]) begin s2[3] = s1[4]; s2[4] = s1[3]; end
      s3 = s2;
      if (s2[3] < s2[0]) begin s3[0] = s2[3]; s3[3] = s2[0]; end
      if (s2[5] < s2[2]) begin s3[2] = s2[5]; s3[5] = s2[2]; end
      s4 = s3;
      if (s3[1] < s3[0]) begin s4[0] = s3[1]; s4[1] = s3[0]; end
      if (s3[3] < s3[2]) begin s4[2] = s3[3]; s4[3] = s3[2]; end
      if (s3[5] < s3[4]) begin s4[4] = s3[5]; s4[5] = s3[4]; end
      s5 = s4;
      if (s4[2] < s4[1]) begin s5[1] = s4[2]; s5[2] = s4[1]; end
      if (s4[4] < s4[3]) begin s5[3] = s4[4]; s5[4] = s4[3]; end
   end

   assign mid_sum = {1'b0, s5[2]} + {1'b0, s5[3]};
   assign mid_avg = mid_sum[8:1];

endmodule

// ===== design/hex_tile_predictive_encoder_unit.sv =====
// top level of the hex tile predictive encoder
//
// Usage: one request carries a hexagonal tile (six ring cells and the
// center, 8 bits each); one response carries the encoded record (type,
// lead byte, seven residuals, byte count).
// Request channel: req_valid / req_stall, taken when valid and not stall.
// Response channel: rsp_valid / rsp_stall, taken the same way.
// Register port: csr_valid / csr_ready / csr_data writes edge_threshold;
// csr_ready is always high. Write it only while the block is idle.
// Path: a taken request is registered in the first stage, then in the
// response register, which drives rsp.
// Throughput: one tile per cycle while rsp_stall is low, set by the
// two-stage lane pipeline (triplet lanes, median network and min/max in
// the first stage, residual lanes and the merge in the second).
// Reset: empties the pipeline and sets edge_threshold to 32.
// Stall: a stalled response holds; the first stage still fills, so
// req_stall rises only when both stages hold tiles and rsp_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hex_tile_predictive_encoder_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  htpe_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output htpe_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_data
);

   localparam int unsigned RingCells = htpe_pkg::RING_CELLS;

   logic [7:0] threshold_ff;
   logic [7:0] threshold_in;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   htpe_pkg::req_payload_type s1_cells_ff;
   htpe_pkg::tile_info_type   s1_info_ff;
   htpe_pkg::tile_info_type   s1_info_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   htpe_pkg::rsp_payload_type rsp_payload_ff;
   htpe_pkg::rsp_payload_type rsp_payload_in;

   logic       adv_out;
   logic       adv_s1;
   logic [7:0] ring [RingCells];
   logic [RingCells-1:0] uniform;
   logic [7:0] mid_avg;
   logic [7:0] mn01, mn23, mn45, mn03, mn4c, mn_all;
   logic [7:0] mx01, mx23, mx45, mx03, mx4c, mx_all;

   logic [7:0] pred;
   logic [7:0] spread;
   logic [7:0] resid [RingCells+1];
   logic [7:0] s1_cell [RingCells+1];

   // register port
   assign csr_ready = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   // pipeline advance
   assign adv_out = !rsp_valid_ff || !rsp_stall;
   assign adv_s1 = !s1_valid_ff || adv_out;
   assign req_stall = !adv_s1;

   // first stage: triplet lanes, median network, min and max
   always_comb begin
      ring[0] = req_payload.cell_0;
      ring[1] = req_payload.cell_1;
      ring[2] = req_payload.cell_2;
      ring[3] = req_payload.cell_3;
      ring[4] = req_payload.cell_4;
      ring[5] = req_payload.cell_5;
   end

   for (genvar k = 0; k < RingCells; k++) begin : g_triplet
      htpe_triplet_lane u_lane (
         .cell_a      (ring[k]),
         .cell_b      (ring[(k + 1) % RingCells]),
         .cell_center (req_payload.cell_center),
         .uniform     (uniform[k])
      );
   end

   htpe_median6 u_median (
      .ring    (ring),
      .mid_avg (mid_avg)
   );

   always_comb begin
      mn01 = (ring[0] < ring[1]) ? ring[0] : ring[1];
      mn23 = (ring[2] < ring[3]) ? ring[2] : ring[3];
      mn45 = (ring[4] < ring[5]) ? ring[4] : ring[5];
      mn03 = (mn01 < mn23) ? mn01 : mn23;
      mn4c = (mn45 < req_payload.cell_center) ? mn45 : req_payload.cell_center;
      mn_all = (mn03 < mn4c) ? mn03 : mn4c;
      mx01 = (ring[0] > ring[1]) ? ring[0] : ring[1];
      mx23 = (ring[2] > ring[3]) ? ring[2] : ring[3];
      mx45 = (ring[4] > ring[5]) ? ring[4] : ring[5];
      mx03 = (mx01 > mx23) ? mx01 : mx23;
      mx4c = (mx45 > req_payload.cell_center) ? mx45 : req_payload.cell_center;
      mx_all = (mx03 > mx4c) ? mx03 : mx4c;
      s1_info_in.flat = (mn_all == mx_all);
      s1_info_in.triplet = |uniform;
      s1_info_in.min_val = mn_all;
      s1_info_in.max_val = mx_all;
      s1_info_in.mid_avg = mid_avg;
   end

   assign s1_valid_in = adv_s1 ? req_valid : s1_valid_ff;

   // second stage: merge and residual lanes
   always_comb begin
      s1_cell[0] = s1_cells_ff.cell_0;
      s1_cell[1] = s1_cells_ff.cell_1;
      s1_cell[2] = s1_cells_ff.cell_2;
      s1_cell[3] = s1_cells_ff.cell_3;
      s1_cell[4] = s1_cells_ff.cell_4;
      s1_cell[5] = s1_cells_ff.cell_5;
      s1_cell[RingCells] = s1_cells_ff.cell_center;
   end

   // every uniform triplet holds the center value
   assign pred = s1_info_ff.triplet ? s1_cells_ff.cell_center : s1_info_ff.mid_avg;
   assign spread = s1_info_ff.max_val - s1_info_ff.min_val;

   for (genvar k = 0; k <= RingCells; k++) begin : g_resid
      htpe_resid_lane u_lane (
         .cell_value (s1_cell[k]),
         .pred       (pred),
         .flat       (s1_info_ff.flat),
         .resid      (resid[k])
      );
   end

   always_comb begin
      rsp_payload_in.resid_0 = resid[0];
      rsp_payload_in.resid_1 = resid[1];
      rsp_payload_in.resid_2 = resid[2];
      rsp_payload_in.resid_3 = resid[3];
      rsp_payload_in.resid_4 = resid[4];
      rsp_payload_in.resid_5 = resid[5];
      rsp_payload_in.resid_center = resid[RingCells];
      if (s1_info_ff.flat) begin
         rsp_payload_in.tile_type = htpe_pkg::TILE_FLAT;
         rsp_payload_in.lead_byte = s1_cells_ff.cell_0;
         rsp_payload_in.byte_count = htpe_pkg::BYTES_FLAT;
      end else begin
         if (s1_info_ff.triplet) begin
            rsp_payload_in.tile_type = htpe_pkg::TILE_TRIPLET;
         end else if (spread > threshold_ff) begin
            rsp_payload_in.tile_type = htpe_pkg::TILE_EDGE;
         end else begin
            rsp_payload_in.tile_type = htpe_pkg::TILE_GRADIENT;
         end
         rsp_payload_in.lead_byte = pred;
         rsp_payload_in.byte_count = htpe_pkg::BYTES_FULL;
      end
   end

   assign rsp_valid_in = adv_out ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= htpe_pkg::EDGE_THRESHOLD_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         s1_cells_ff <= req_payload;
         s1_info_ff <= s1_info_in;
      end
      if (adv_out) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_IMPL(a_flat_record, clock, reset,
      rsp_valid && (rsp_payload.tile_type == htpe_pkg::TILE_FLAT),
      (rsp_payload.byte_count == htpe_pkg::BYTES_FLAT) && (rsp_payload.resid_center == 8'd0))
   `ASSERT_IMPL(a_full_record, clock, reset,
      rsp_valid && (rsp_payload.tile_type != htpe_pkg::TILE_FLAT),
      rsp_payload.byte_count == htpe_pkg::BYTES_FULL)
   `ASSERT_IMPL(a_triplet_center, clock, reset,
      rsp_valid && (rsp_payload.tile_type == htpe_pkg::TILE_TRIPLET),
      rsp_payload.resid_center == htpe_pkg::RESID_OFFSET)
   `ASSERT_IMPL(a_full_pipe_stalls, clock, reset,
      s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall)
   `ASSERT_NEXT(a_stage_moves, clock, reset,
      s1_valid_ff && !rsp_valid_ff, rsp_valid_ff)

endmodule

// ===== tb/sv/hex_tile_predictive_encoder_unit_tb.sv =====
// testbench of the hex tile predictive encoder: random and directed tiles against a predictor
`timescale 1ns / 1ps

module hex_tile_predictive_encoder_unit_tb;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   htpe_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   htpe_pkg::rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   htpe_pkg::req_payload_type tile_queue[$];
   htpe_pkg::rsp_payload_type predicted_records[$];
   htpe_pkg::rsp_payload_type next_record;
   logic [7:0] edge_threshold_model = htpe_pkg::EDGE_THRESHOLD_RESET;

   int tiles_queued = 0;
   int tiles_sent = 0;
   int records_seen = 0;
   int kind_count[4] = '{0, 0, 0, 0};
   int csr_writes = 0;
   int drain_pauses = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic req_fired = 1'b0;
   logic drain_wait = 1'b0;
   logic any_fired;

   hex_tile_predictive_encoder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic htpe_pkg::rsp_payload_type encode_tile(
      input htpe_pkg::req_payload_type t,
      input logic [7:0] thr);
      logic [7:0] c [0:6];
      logic [7:0] r [0:5];
      logic [7:0] pred;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] x;
      logic [8:0] sum;
      logic same;
      logic found;
      htpe_pkg::rsp_payload_type o;
      int a;
      int b;
      int k;
      c[0] = t.cell_0;
      c[1] = t.cell_1;
      c[2] = t.cell_2;
      c[3] = t.cell_3;
      c[4] = t.cell_4;
      c[5] = t.cell_5;
      c[6] = t.cell_center;
      o = '0;
      same = 1'b1;
      for (k = 1; k < 7; k++) begin
         if (c[k] != c[0]) same = 1'b0;
      end
      if (same) begin
         o.tile_type = htpe_pkg::TILE_FLAT;
         o.lead_byte = c[0];
         o.byte_count = htpe_pkg::BYTES_FLAT;
         return o;
      end
      found = 1'b0;
      pred = '0;
      for (k = 0; k < 6; k++) begin
         if (!found && c[k] == c[(k + 1) % 6] && c[k] == c[6]) begin
            found = 1'b1;
            pred = c[k];
         end
      end
      if (found) begin
         o.tile_type = htpe_pkg::TILE_TRIPLET;
      end else begin
         lo = c[0];
         hi = c[0];
         for (k = 1; k < 7; k++) begin
            if (c[k] < lo) lo = c[k];
            if (c[k] > hi) hi = c[k];
         end
         o.tile_type = (hi - lo > thr) ? htpe_pkg::TILE_EDGE : htpe_pkg::TILE_GRADIENT;
         for (k = 0; k < 6; k++) r[k] = c[k];
         for (a = 0; a < 5; a++) begin
            for (b = a + 1; b < 6; b++) begin
               if (r[b] < r[a]) begin
                  x = r[a];
                  r[a] = r[b];
                  r[b] = x;
               end
            end
         end
         sum = {1'b0, r[2]} + {1'b0, r[3]};
         pred = sum[8:1];
      end
      o.lead_byte = pred;
      o.resid_0 = c[0] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_1 = c[1] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_2 = c[2] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_3 = c[3] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_4 = c[4] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_5 = c[5] - pred + htpe_pkg::RESID_OFFSET;
      o.resid_center = c[6] - pred + htpe_pkg::RESID_OFFSET;
      o.byte_count = htpe_pkg::BYTES_FULL;
      return o;
   endfunction

   // mostly shaped tiles: flat or nearly flat, triplets, spreads around the threshold, narrow ranges
   function automatic htpe_pkg::req_payload_type random_tile(input logic [7:0] thr);
      logic [7:0] c [0:6];
      logic [7:0] v;
      int pick;
      int s;
      int b;
      int k;
      int lo_i;
      int hi_i;
      pick = $urandom_range(0, 99);
      for (k = 0; k < 7; k++) c[k] = 8'($urandom_range(0, 255));
      if (pick < 12) begin
         v = 8'($urandom_range(0, 255));
         for (k = 0; k < 7; k++) c[k] = v;
         if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, 6);
            c[k] = c[k] ^ (8'd1 << $urandom_range(0, 7));
         end
      end else if (pick < 37) begin
         v = 8'($urandom_range(0, 255));
         k = $urandom_range(0, 5);
         c[k] = v;
         c[(k + 1) % 6] = v;
         c[6] = v;
      end else if (pick < 57) begin
         s = int'(thr) + int'($urandom_range(0, 2)) - 1;
         if (s < 0) s = 0;
         if (s > 255) s = 255;
         b = $urandom_range(0, 255 - s);
         for (k = 0; k < 7; k++) c[k] = 8'(b + int'($urandom_range(0, s)));
         lo_i = $urandom_range(0, 6);
         hi_i = (lo_i + int'($urandom_range(1, 6))) % 7;
         c[lo_i] = 8'(b);
         c[hi_i] = 8'(b + s);
      end else if (pick < 77) begin
         b = $urandom_range(0, 240);
         for (k = 0; k < 7; k++) c[k] = 8'(b + int'($urandom_range(0, 15)));
      end
      return {c[0], c[1], c[2], c[3], c[4], c[5], c[6]};
   endfunction

   task automatic queue_tile(input htpe_pkg::req_payload_type t);
      tile_queue.push_back(t);
      tiles_queued++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic wait_drained;
      do @(negedge clock);
      while (tiles_sent != tiles_queued || predicted_records.size() != 0);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      @(posedge clock);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) queue_tile(random_tile(edge_threshold_model));
      wait_drained();
   endtask

   // request driver and response stall
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
         drain_wait = 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (drain_wait && predicted_records.size() == 0) drain_wait = 1'b0;
         if (!req_valid || req_fired) begin
            if (tile_queue.size() > 0 && !drain_wait &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               if (predicted_records.size() > 0 && $urandom_range(0, 99) < 2) begin
                  drain_wait = 1'b1;
                  drain_pauses++;
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_payload <= tile_queue.pop_front();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         any_fired = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            any_fired = 1'b1;
            records_seen++;
            if (predicted_records.size() == 0) begin
               $display("%0t ns: response with no request pending, actual %0h",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               next_record = predicted_records.pop_front();
               check_field("tile_type", 8'(next_record.tile_type), 8'(rsp_payload.tile_type));
               check_field("lead_byte", next_record.lead_byte, rsp_payload.lead_byte);
               check_field("resid_0", next_record.resid_0, rsp_payload.resid_0);
               check_field("resid_1", next_record.resid_1, rsp_payload.resid_1);
               check_field("resid_2", next_record.resid_2, rsp_payload.resid_2);
               check_field("resid_3", next_record.resid_3, rsp_payload.resid_3);
               check_field("resid_4", next_record.resid_4, rsp_payload.resid_4);
               check_field("resid_5", next_record.resid_5, rsp_payload.resid_5);
               check_field("resid_center", next_record.resid_center, rsp_payload.resid_center);
               check_field("byte_count", 8'(next_record.byte_count), 8'(rsp_payload.byte_count));
            end
         end
         if (req_valid && !req_stall) begin
            req_fired = 1'b1;
            any_fired = 1'b1;
            next_record = encode_tile(req_payload, edge_threshold_model);
            predicted_records.push_back(next_record);
            kind_count[next_record.tile_type]++;
            tiles_sent++;
         end
         if (csr_valid && csr_ready) begin
            any_fired = 1'b1;
            edge_threshold_model = csr_data;
            csr_writes++;
         end
         idle_cycles = any_fired ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("hex_tile_predictive_encoder_unit_tb NOT OK");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flat tiles
      queue_tile({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      queue_tile({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      queue_tile({8'h5a, 8'h5a, 8'h5a, 8'h5a, 8'h5a, 8'h5a, 8'h5a});
      queue_tile({8'ha5, 8'ha5, 8'ha5, 8'ha5, 8'ha5, 8'ha5, 8'ha5});
      // a uniform triplet at each ring position
      queue_tile({8'h40, 8'h40, 8'h11, 8'h22, 8'h33, 8'h44, 8'h40});
      queue_tile({8'h11, 8'h40, 8'h40, 8'h22, 8'h33, 8'h44, 8'h40});
      queue_tile({8'h11, 8'h22, 8'h40, 8'h40, 8'h33, 8'h44, 8'h40});
      queue_tile({8'h11, 8'h22, 8'h33, 8'h40, 8'h40, 8'h44, 8'h40});
      queue_tile({8'h11, 8'h22, 8'h33, 8'h44, 8'h40, 8'h40, 8'h40});
      queue_tile({8'h40, 8'h11, 8'h22, 8'h33, 8'h44, 8'h40, 8'h40});
      // equal ring pair or equal ring without the center
      queue_tile({8'h10, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60});
      queue_tile({8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h78});
      // spread one below, equal to and one above the reset threshold
      queue_tile({8'd100, 8'd110, 8'd120, 8'd131, 8'd105, 8'd115, 8'd125});
      queue_tile({8'd100, 8'd110, 8'd120, 8'd132, 8'd105, 8'd115, 8'd125});
      queue_tile({8'd100, 8'd110, 8'd120, 8'd133, 8'd105, 8'd115, 8'd125});
      // extremes, odd middle sum and residual wrap
      queue_tile({8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80});
      queue_tile({8'hff, 8'hfe, 8'hfd, 8'hfc, 8'hfb, 8'hfa, 8'h00});
      queue_tile({8'd0, 8'd0, 8'd10, 8'd11, 8'd255, 8'd255, 8'd200});
      queue_tile({8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'hff});

      run_phase(0, 0, 100);
      write_threshold(8'd0);
      run_phase(64, 0, 100);
      write_threshold(8'd255);
      run_phase(0, 64, 100);
      write_threshold(8'($urandom_range(0, 255)));
      run_phase(22, 22, 100);
      write_threshold(8'd1);
      run_phase(0, 0, 100);
      write_threshold(8'($urandom_range(0, 255)));
      run_phase(22, 22, 100);

      repeat (8) @(posedge clock);
      if (predicted_records.size() != 0) begin
         $display("%0t ns: %0d responses never arrived", $time, predicted_records.size());
         fail_count++;
      end
      $display("encoded %0d tiles: %0d flat, %0d triplet, %0d gradient, %0d edge",
               tiles_sent, kind_count[htpe_pkg::TILE_FLAT],
               kind_count[htpe_pkg::TILE_TRIPLET],
               kind_count[htpe_pkg::TILE_GRADIENT], kind_count[htpe_pkg::TILE_EDGE]);
      $display("%0d threshold writes, %0d drain pauses, %0d responses, %0d mismatches",
               csr_writes, drain_pauses, records_seen, fail_count);
      if (fail_count == 0) begin
         $display("hex_tile_predictive_encoder_unit_tb OK");
      end else begin
         $display("hex_tile_predictive_encoder_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
